[sv/lpp_pkg.sv]
// shared types and constants for the lead point predictor
package lpp_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned STAMP_W = 48;
    localparam int unsigned SPEED_W = 31;
    localparam int unsigned INTV_W  = 20;
    localparam int unsigned DIV_W   = 64;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 31'd983040;
    localparam logic [INTV_W-1:0]  INTV_RESET  = 20'd1000;
    localparam logic [31:0]        US_PER_S    = 32'd1000000;

    typedef enum logic [0:0] {
        CFG_SPEED = 1'b0,
        CFG_INTV  = 1'b1
    } t_cfg_idx;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [DIV_W-1:0]        t_word;

endpackage

[sv/lpp_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module lpp_div
    import lpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output t_word o_quotient,
    output logic  o_done
);

    logic [DIV_W:0]         r_rem;
    t_word                  r_dvd;
    t_word                  r_dvs;
    logic [$clog2(DIV_W):0] r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [DIV_W:0] w_sh;
    logic           w_ge;

    assign w_sh = {r_rem[DIV_W-1:0], r_dvd[DIV_W-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(DIV_W)+1)'(DIV_W);
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
                r_dvd <= {r_dvd[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_dvd;
    assign o_done     = r_done;

endmodule

[sv/lead_point_predictor_core.sv]
// lead point predictor top level: velocity estimate, range, aim point
// One transaction in, one aim point out. An item runs through a small sequencer
// around one shared 33x32 multiplier, a 64-bit restoring divider and a bit-pair
// square root. An item runs three offset divisions, plus three velocity
// divisions when the velocity is re-estimated rather than kept, and no new
// transaction is accepted until it is finished. Input stall is high while an
// item is in work; a finished aim point waits in the output register while the
// next transaction is accepted. Config writes are taken at any time but belong
// in idle periods.
module lead_point_predictor_core
    import lpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [STAMP_W-1:0]   i_stamp_us,
    input  t_pos                 i_pos_x,
    input  t_pos                 i_pos_y,
    input  t_pos                 i_pos_z,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_pos                 o_aim_x,
    output t_pos                 o_aim_y,
    output t_pos                 o_aim_z,
    output logic [STAMP_W-1:0]   o_aim_stamp_us,
    // config write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SPEED_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQACC, S_SQRT, S_MUL_V, S_MUL_A,
        S_DSTART, S_DWAIT, S_VFIN, S_AFIN, S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_ax;
    logic                 r_aimph;   // divider serves the offset phase
    logic                 r_upd;     // velocity is re-estimated
    logic [SPEED_W-1:0]   r_speed;
    logic [INTV_W-1:0]    r_minint;
    logic [STAMP_W-1:0]   r_stamp;
    logic [STAMP_W-1:0]   r_prev_stamp;
    logic [STAMP_W-1:0]   r_dt;
    t_pos                 r_pos  [3];
    t_pos                 r_prev [3];
    t_pos                 r_vel  [3];
    t_pos                 r_aim  [3];
    t_word                r_prod;
    t_word                r_acc;
    // square root
    t_word                r_sv;
    t_word                r_sr;
    t_word                r_sb;
    // output register
    logic                 r_oval;
    logic [STAMP_W-1:0]   r_ostamp;
    t_pos                 r_oaim [3];

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic [STAMP_W:0]     w_dt;
    logic signed [32:0]   w_diff;
    logic [32:0]          w_dmag;
    logic [31:0]          w_pmag;
    logic [31:0]          w_vmag;
    logic [32:0]          w_ma;
    logic [31:0]          w_mb;
    logic [64:0]          w_prod;
    t_word                w_srb;
    logic                 w_div_start;
    t_word                w_div_dvs;
    t_word                w_q;
    logic                 w_div_done;
    logic [33:0]          w_off;
    logic signed [35:0]   w_sum;
    t_pos                 w_velv;
    t_pos                 w_aimv;
    logic [SPEED_W-1:0]   w_speed;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_oval && !i_stall;
    assign o_stall   = (r_state != S_IDLE);

    // signed elapsed time, negative when time runs backwards
    assign w_dt = {1'b0, i_stamp_us} - {1'b0, r_prev_stamp};

    assign w_diff = {r_pos[r_ax][31], r_pos[r_ax]} - {r_prev[r_ax][31], r_prev[r_ax]};
    assign w_dmag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_pmag = r_pos[r_ax][31] ? 32'(-r_pos[r_ax]) : 32'(r_pos[r_ax]);
    assign w_vmag = r_vel[r_ax][31] ? 32'(-r_vel[r_ax]) : 32'(r_vel[r_ax]);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SQ: begin
                w_ma = {1'b0, w_pmag};
                w_mb = w_pmag;
            end
            S_MUL_V: begin
                w_ma = w_dmag;
                w_mb = US_PER_S;
            end
            default: begin
                w_ma = {1'b0, w_vmag};
                w_mb = r_sr[31:0];
            end
        endcase
    end
    assign w_prod = 65'(w_ma) * 65'(w_mb);

    assign w_srb = r_sr + r_sb;

    assign w_speed     = (r_speed == '0) ? SPEED_W'(1) : r_speed;
    assign w_div_start = (r_state == S_DSTART);
    assign w_div_dvs   = r_aimph ? DIV_W'(w_speed) : DIV_W'(r_dt);

    lpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_div_dvs),
        .o_quotient (w_q),
        .o_done     (w_div_done)
    );

    // velocity from the magnitude quotient, truncated toward zero and saturated
    always_comb begin
        if (!w_diff[32]) begin
            w_velv = (w_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : t_pos'(w_q[31:0]);
        end else begin
            w_velv = (w_q > 64'h8000_0000) ? 32'sh8000_0000 : t_pos'(-w_q[31:0]);
        end
    end

    // offset clamped, then added with the sign of the velocity and saturated
    assign w_off = (w_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : w_q[33:0];
    assign w_sum = r_vel[r_ax][31]
                 ? (36'(r_pos[r_ax]) - $signed({2'b00, w_off}))
                 : (36'(r_pos[r_ax]) + $signed({2'b00, w_off}));
    always_comb begin
        if (w_sum > 36'sh0_7FFF_FFFF) begin
            w_aimv = 32'sh7FFF_FFFF;
        end else if (w_sum < -36'sh0_8000_0000) begin
            w_aimv = 32'sh8000_0000;
        end else begin
            w_aimv = t_pos'(w_sum[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ax         <= '0;
            r_aimph      <= 1'b0;
            r_upd        <= 1'b0;
            r_speed      <= SPEED_RESET;
            r_minint     <= INTV_RESET;
            r_prev_stamp <= '0;
            r_oval       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
                r_vel[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SPEED: r_speed  <= i_cfg_data;
                    CFG_INTV:  r_minint <= i_cfg_data[INTV_W-1:0];
                    default:   ;
                endcase
            end
            // a reload in the done state keeps the output register full
            if (w_out_acc && r_state != S_DONE) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_stamp  <= i_stamp_us;
                        r_pos[0] <= i_pos_x;
                        r_pos[1] <= i_pos_y;
                        r_pos[2] <= i_pos_z;
                        r_dt     <= w_dt[STAMP_W-1:0];
                        r_upd    <= !w_dt[STAMP_W] &&
                                    (w_dt[STAMP_W-1:0] > STAMP_W'(r_minint));
                        r_acc    <= '0;
                        r_ax     <= '0;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod  <= w_prod[63:0];
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_ax == 2'd2) begin
                        r_sv    <= r_acc + r_prod;
                        r_sr    <= '0;
                        r_sb    <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: begin
                    if (r_sb == '0) begin
                        r_ax    <= '0;
                        r_aimph <= !r_upd;
                        r_state <= r_upd ? S_MUL_V : S_MUL_A;
                    end else begin
                        if (r_sv >= w_srb) begin
                            r_sv <= r_sv - w_srb;
                            r_sr <= (r_sr >> 1) + r_sb;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sb <= r_sb >> 2;
                    end
                end
                S_MUL_V, S_MUL_A: begin
                    r_prod  <= w_prod[63:0];
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_state <= r_aimph ? S_AFIN : S_VFIN;
                    end
                end
                S_VFIN: begin
                    r_vel[r_ax] <= w_velv;
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_aimph <= 1'b1;
                        r_state <= S_MUL_A;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_MUL_V;
                    end
                end
                S_AFIN: begin
                    r_aim[r_ax] <= w_aimv;
                    if (r_ax == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_MUL_A;
                    end
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (!r_oval || w_out_acc) begin
                        r_oval       <= 1'b1;
                        r_ostamp     <= r_stamp;
                        r_oaim[0]    <= r_aim[0];
                        r_oaim[1]    <= r_aim[1];
                        r_oaim[2]    <= r_aim[2];
                        r_prev[0]    <= r_pos[0];
                        r_prev[1]    <= r_pos[1];
                        r_prev[2]    <= r_pos[2];
                        r_prev_stamp <= r_stamp;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_aim_x        = r_oaim[0];
    assign o_aim_y        = r_oaim[1];
    assign o_aim_z        = r_oaim[2];
    assign o_aim_stamp_us = r_ostamp;

    // accepted transaction always starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_SQ)
        else $error("sequencer did not start");

    // velocity is only rewritten when the interval was exceeded
    a_vel_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_VFIN |-> r_upd && !r_aimph)
        else $error("velocity written without update");

    // a taken result clears the output register unless a new one loads
    a_out_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_state != S_DONE) |=> !r_oval)
        else $error("output register not released");

endmodule

[sim/lpp_checker.sv]
// scoreboard for the lead point predictor: watches both channels, predicts, compares
`timescale 1ns / 1ps
module lpp_checker
    import lpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  logic [STAMP_W-1:0]   i_stamp_us,
    input  t_pos                 i_pos_x,
    input  t_pos                 i_pos_y,
    input  t_pos                 i_pos_z,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_pos                 i_aim_x,
    input  t_pos                 i_aim_y,
    input  t_pos                 i_aim_z,
    input  logic [STAMP_W-1:0]   i_aim_stamp_us,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SPEED_W-1:0]   i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [47:0]        stamp;
    } t_aim;

    t_aim aim_q[$];

    logic [SPEED_W-1:0] speed_r;
    logic [INTV_W-1:0]  intv_r;
    longint             last_x, last_y, last_z, vx, vy, vz;
    logic [47:0]        last_stamp;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // offset magnitude fits in 63 bits; 128-bit math keeps the product exact before clamping
    function automatic logic signed [31:0] lead_axis(longint p, longint v,
                                                     logic [63:0] rng,
                                                     logic [63:0] spd);
        logic [127:0] off;
        longint       s;
        logic [63:0]  m;
        m = (v < 0) ? -v : v;
        off = ({64'd0, m} * {64'd0, rng}) / {64'd0, spd};
        if (off > (128'd1 << 33)) off = 128'd1 << 33;
        s = (v < 0) ? p - longint'(off[63:0]) : p + longint'(off[63:0]);
        return 32'(clamp32(s));
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_v);
        $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
        o_errors = o_errors + 1;
    endtask

    task automatic predict_aim();
        longint      x, y, z, dt;
        logic [63:0] sq, rng, spd;
        t_aim        a;
        x = i_pos_x; y = i_pos_y; z = i_pos_z;
        dt = longint'({16'd0, i_stamp_us}) - longint'({16'd0, last_stamp});
        if (dt > longint'({44'd0, intv_r})) begin
            vx = clamp32(((x - last_x) * 1000000) / dt);
            vy = clamp32(((y - last_y) * 1000000) / dt);
            vz = clamp32(((z - last_z) * 1000000) / dt);
        end
        sq = x*x + y*y + z*z;
        rng = int_sqrt(sq);
        spd = (speed_r == 0) ? 64'd1 : {33'd0, speed_r};
        a.x = lead_axis(x, vx, rng, spd);
        a.y = lead_axis(y, vy, rng, spd);
        a.z = lead_axis(z, vz, rng, spd);
        a.stamp = i_stamp_us;
        aim_q.push_back(a);
        last_x = x; last_y = y; last_z = z;
        last_stamp = i_stamp_us;
    endtask

    initial o_errors = 0;
    assign o_pending = aim_q.size();

    always @(posedge i_clk) begin
        t_aim e;
        if (!i_rst_n) begin
            speed_r <= SPEED_RESET;
            intv_r  <= INTV_RESET;
            last_x = 0; last_y = 0; last_z = 0;
            vx = 0; vy = 0; vz = 0;
            last_stamp = 0;
            aim_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (aim_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = aim_q.pop_front();
                    if (i_aim_x !== e.x) report_mismatch("aim_x", i_aim_x, e.x);
                    if (i_aim_y !== e.y) report_mismatch("aim_y", i_aim_y, e.y);
                    if (i_aim_z !== e.z) report_mismatch("aim_z", i_aim_z, e.z);
                    if (i_aim_stamp_us !== e.stamp)
                        report_mismatch("aim_stamp_us", i_aim_stamp_us, e.stamp);
                end
            end
            if (i_valid && !i_stall_in) predict_aim();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SPEED) speed_r <= i_cfg_data;
                else intv_r <= i_cfg_data[INTV_W-1:0];
            end
        end
    end

endmodule

[sim/tb_top.sv]
// stimulus and verdict for the lead point predictor
`timescale 1ns / 1ps
module tb_top;
    import lpp_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [STAMP_W-1:0] stamp = 0;
    t_pos               px = 0, py = 0, pz = 0;
    logic               out_valid;
    logic               out_stall = 0;
    t_pos               ax, ay, az;
    logic [STAMP_W-1:0] astamp;
    logic               cfg_we = 0;
    logic               cfg_idx = 0;
    logic [SPEED_W-1:0] cfg_data = 0;
    int                 errors, pending;
    int                 cycles = 0;
    bit                 calm = 0;     // long stretch without idling
    logic [47:0]        clock_us = 0; // running timestamp for well-formed tracks

    localparam int CYCLE_LIMIT = 3000000;

    always #2 i_clk = ~i_clk;

    lead_point_predictor_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_stamp_us(stamp), .i_pos_x(px), .i_pos_y(py), .i_pos_z(pz),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_aim_x(ax), .o_aim_y(ay), .o_aim_z(az), .o_aim_stamp_us(astamp),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    lpp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_stamp_us(stamp), .i_pos_x(px), .i_pos_y(py), .i_pos_z(pz),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_aim_x(ax), .i_aim_y(ay), .i_aim_z(az), .i_aim_stamp_us(astamp),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls at random, except during the calm stretch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 6);
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one transaction: optional idle gap, then hold valid until accepted
    task automatic send_point(logic [47:0] s, t_pos x, t_pos y, t_pos z);
        while (!calm && $urandom_range(99) < 6) @(posedge i_clk);
        in_valid <= 1;
        stamp <= s; px <= x; py <= y; pz <= z;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        in_valid <= 0;
        @(posedge i_clk);
    endtask

    // config only while idle: drain results, then let the core settle
    task automatic write_reg(t_cfg_idx idx, logic [SPEED_W-1:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    function automatic t_pos rand_pos(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(2000000)) - 1000000;  // near origin
            default: return $signed($urandom_range(40000000)) - 20000000;
        endcase
    endfunction

    initial begin
        int mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, first item from origin, time standing still and going back
        send_point(48'd5000, 32'sh10000, -32'sh20000, 32'sh30000);
        send_point(48'd5000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_point(48'd4000, -32'sh80000000, -32'sh80000000, -32'sh80000000);
        send_point(48'd6001, 0, 0, 0);
        send_point(48'd6002, 32'sh7fffffff, -32'sh80000000, 0);
        send_point(48'hffffffffffff, 32'sh100, 32'sh200, -32'sh300);
        send_point(48'd0, -32'sh80000000, 32'sh7fffffff, 32'sh1);
        send_point(48'hffffffffffff, 32'sh7fffffff, 32'sh7fffffff, -32'sh80000000);
        // smallest speed saturates along the velocity
        write_reg(CFG_SPEED, 31'd0);
        send_point(48'h1000000, 32'sh10000, 32'sh10000, 32'sh10000);
        send_point(48'h2000000, 32'sh20000, -32'sh10000, 32'sh0);
        write_reg(CFG_SPEED, 31'h7fffffff);
        send_point(48'h3000000, 32'sh40000000, 32'sh40000000, -32'sh40000000);
        write_reg(CFG_INTV, 31'hfffff);   // largest interval the 20-bit register holds
        send_point(48'h3000400, 32'sh1, 32'sh2, 32'sh3);
        send_point(48'h3200000, -32'sh1, -32'sh2, -32'sh3);
        write_reg(CFG_INTV, 31'd0);
        send_point(48'h3200000, 32'sh5, 32'sh5, 32'sh5);
        send_point(48'h3200001, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff);
        write_reg(CFG_SPEED, 31'd1);
        send_point(48'h3200003, 32'sh1234, -32'sh1234, 32'sh0);

        // random phases with varying settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_SPEED, SPEED_RESET);
                         write_reg(CFG_INTV, SPEED_W'(INTV_RESET)); end
                1: begin write_reg(CFG_SPEED, SPEED_W'($urandom_range(2000000, 1)));
                         write_reg(CFG_INTV, SPEED_W'($urandom_range(1000000))); end
                2: begin write_reg(CFG_SPEED, 31'd1); write_reg(CFG_INTV, 31'd0); end
                3: begin write_reg(CFG_SPEED, 31'h7fffffff);
                         write_reg(CFG_INTV, 31'd1000000); end
                4: begin write_reg(CFG_SPEED, SPEED_W'($urandom()));
                         write_reg(CFG_INTV, SPEED_W'($urandom())); end
                default: begin write_reg(CFG_SPEED, 31'd58982400);
                               write_reg(CFG_INTV, 31'd33333); end
            endcase
            calm = (ph == 2);
            for (int n = 0; n < 272; n++) begin
                if (n == 136) while (pending != 0) @(posedge i_clk);
                mode = $urandom_range(9);
                if (mode < 8) begin
                    // well-formed track: time never runs backwards
                    clock_us = clock_us + $urandom_range(100000);
                    send_point(clock_us, rand_pos(mode % 3), rand_pos(mode % 3),
                               rand_pos(mode % 3));
                end else begin
                    send_point(48'({$urandom(), $urandom()}), rand_pos(0), rand_pos(0),
                               rand_pos(0));
                end
            end
        end
        calm = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/lpp_pkg.sv
sv/lpp_div.sv
sv/lead_point_predictor_core.sv
sim/lpp_checker.sv
sim/tb_top.sv
